// File: hdl/cset_pkg.sv
// ----------------------------------------------------------------------------
// cset_pkg
// shared widths, codes and types of the call stack exclusive time profiler
// ----------------------------------------------------------------------------
package cset_pkg;

   localparam int MAX_FUNCS   = 256;
   localparam int STACK_DEPTH = 64;
   localparam int TIME_W      = 32;
   localparam int FUNC_W      = $clog2(MAX_FUNCS);
   localparam int SADDR_W     = $clog2(STACK_DEPTH);
   localparam int SP_W        = SADDR_W + 1;
   localparam int NFUNC_W     = 9;
   localparam int ERR_W       = 2;

   localparam int REQ_DATA_W  = 40;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_DATA_W  = 48;
   localparam int RSP_USER_W  = 3;

   localparam logic [NFUNC_W-1:0] NFUNC_RESET = NFUNC_W'(MAX_FUNCS);

   typedef enum logic [ERR_W-1:0] {
      ERR_OK        = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_BAD_ID    = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_TOP  = 3'b010,
      ST_ACC  = 3'b100
   } state_type;

   typedef struct packed {
      logic               en;
      logic [SADDR_W-1:0] addr;
      logic [FUNC_W-1:0]  data;
   } stk_wr_type;

   typedef struct packed {
      logic              en;
      logic [FUNC_W-1:0] addr;
      logic [TIME_W-1:0] data;
   } tot_wr_type;

endpackage

// File: hdl/cset_stack.sv
// ----------------------------------------------------------------------------
// cset_stack
// call stack memory of function ids, one write and one registered read port
// ----------------------------------------------------------------------------
module cset_stack import cset_pkg::*; (
   input  logic               clock,
   input  logic [SADDR_W-1:0] rd_addr,
   output logic [FUNC_W-1:0]  rd_data,
   input  stk_wr_type         wr
);

   logic [FUNC_W-1:0] mem_ff [STACK_DEPTH];
   logic [FUNC_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cset_totals.sv
// ----------------------------------------------------------------------------
// cset_totals
// exclusive time table per function id, entries read as zero until written
// ----------------------------------------------------------------------------
module cset_totals import cset_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [FUNC_W-1:0] rd_addr,
   output logic [TIME_W-1:0] rd_data,
   input  tot_wr_type        wr
);

   logic [TIME_W-1:0]    mem_ff [MAX_FUNCS];
   logic [MAX_FUNCS-1:0] valid_ff;
   logic [TIME_W-1:0]    rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: hdl/call_stack_exclusive_time.sv
// ----------------------------------------------------------------------------
// call_stack_exclusive_time
// exclusive time profiler for nested function calls
// ----------------------------------------------------------------------------
// trace events enter on the req stream: tuser carries the start flag, tdata
// the function id and the timestamp. each event gives exactly one transfer
// on the rsp stream with the credited id, its new saturated total, the stack
// depth after the event and an error code.
// the user must write num_functions on the csr channel only while no event
// is in flight; the block does not enforce it. ids at or above it are rejected.
// an event is handled in order: the stack top is read, then the total of
// that id, then the delta is added and the new total is written back.
// the next event is accepted in the cycle after the result is loaded, so
// events do not overlap, as the reads of the stack and the totals table
// depend on each other.
// reset empties the stack, clears the time mark and all totals, and sets
// num_functions to 256; no pass over the memories is needed.
// a stalled rsp holds its result; one further event is accepted and waits
// in its final step until the output register frees.
// ----------------------------------------------------------------------------
module call_stack_exclusive_time import cset_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: func_id[7:0], timestamp[39:8]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: is_start[0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rsp_tdata: credited_id[7:0], credited_total[39:8], depth[46:40], zero[47]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: credit_valid[0], error[2:1]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [NFUNC_W-1:0]    csr_wdata,
   input  logic                  csr_valid,
   output logic                  csr_ready
);

   state_type          state_ff, state_in;
   logic               start_ff;
   logic [FUNC_W-1:0]  id_ff;
   logic [TIME_W-1:0]  time_ff;
   logic [SP_W-1:0]    sp_ff, sp_in;
   logic [TIME_W-1:0]  mark_ff, mark_in;
   logic [NFUNC_W-1:0] nfunc_ff;
   err_type            err_ff, err_in;
   logic               credit_ff, credit_in;
   logic [FUNC_W-1:0]  top_ff;
   logic [TIME_W-1:0]  delta_ff, delta_in;

   logic               rsp_valid_ff;
   logic               rsp_credit_ff;
   logic [FUNC_W-1:0]  rsp_id_ff;
   logic [TIME_W-1:0]  rsp_total_ff;
   logic [SP_W-1:0]    rsp_depth_ff;
   err_type            rsp_err_ff;

   logic               req_fire;
   logic               acc_fire;
   logic               in_start;
   logic [FUNC_W-1:0]  in_id;
   logic [TIME_W-1:0]  in_time;
   logic [FUNC_W-1:0]  stk_rd_data;
   logic [TIME_W-1:0]  tot_rd_data;
   logic [TIME_W:0]    diff;
   logic [TIME_W:0]    sum;
   logic [TIME_W:0]    time_inc;
   logic [TIME_W-1:0]  new_total;
   stk_wr_type         stk_wr;
   tot_wr_type         tot_wr;

   assign in_start   = req_tuser[0];
   assign in_id      = req_tdata[FUNC_W-1:0];
   assign in_time    = req_tdata[FUNC_W +: TIME_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign acc_fire   = (state_ff == ST_ACC) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   // checks on accept, bad id first
   always_comb begin
      err_in    = ERR_OK;
      credit_in = 1'b0;
      if ({1'b0, in_id} >= nfunc_ff) begin
         err_in = ERR_BAD_ID;
      end else if (in_start) begin
         if (sp_ff >= SP_W'(STACK_DEPTH)) begin
            err_in = ERR_OVERFLOW;
         end else begin
            credit_in = (sp_ff != '0);
         end
      end else begin
         if (sp_ff == '0) begin
            err_in = ERR_UNDERFLOW;
         end else begin
            credit_in = 1'b1;
         end
      end
   end

   // interval since the mark, clamped at zero, plus one on end events, saturating
   always_comb begin
      diff = {1'b0, time_ff} - {1'b0, mark_ff};
      if (diff[TIME_W]) begin
         delta_in = '0;
      end else if (start_ff || (&diff[TIME_W-1:0])) begin
         delta_in = diff[TIME_W-1:0];
      end else begin
         delta_in = diff[TIME_W-1:0] + TIME_W'(1);
      end
   end

   assign sum       = {1'b0, tot_rd_data} + {1'b0, delta_ff};
   assign new_total = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   assign time_inc  = {1'b0, time_ff} + (TIME_W+1)'(1);

   always_comb begin
      sp_in   = sp_ff;
      mark_in = mark_ff;
      if (err_ff == ERR_OK) begin
         if (start_ff) begin
            sp_in   = sp_ff + SP_W'(1);
            mark_in = time_ff;
         end else begin
            sp_in   = sp_ff - SP_W'(1);
            mark_in = time_inc[TIME_W] ? '1 : time_inc[TIME_W-1:0];
         end
      end
   end

   always_comb begin
      stk_wr.en    = acc_fire && (err_ff == ERR_OK) && start_ff;
      stk_wr.addr  = sp_ff[SADDR_W-1:0];
      stk_wr.data  = id_ff;
      tot_wr.en    = acc_fire && (err_ff == ERR_OK) && credit_ff;
      tot_wr.addr  = top_ff;
      tot_wr.data  = new_total;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_TOP;
            end
         end
         ST_TOP: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (acc_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   cset_stack u_stack (
      .clock   (clock),
      .rd_addr (sp_ff[SADDR_W-1:0] - SADDR_W'(1)),
      .rd_data (stk_rd_data),
      .wr      (stk_wr)
   );

   cset_totals u_totals (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (stk_rd_data),
      .rd_data (tot_rd_data),
      .wr      (tot_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         mark_ff      <= '0;
         nfunc_ff     <= NFUNC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            nfunc_ff <= csr_wdata;
         end
         if (acc_fire) begin
            sp_ff        <= sp_in;
            mark_ff      <= mark_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         start_ff  <= in_start;
         id_ff     <= in_id;
         time_ff   <= in_time;
         err_ff    <= err_in;
         credit_ff <= credit_in;
      end
      if (state_ff == ST_TOP) begin
         top_ff   <= stk_rd_data;
         delta_ff <= delta_in;
      end
      if (acc_fire) begin
         rsp_credit_ff <= credit_ff && (err_ff == ERR_OK);
         rsp_id_ff     <= (credit_ff && (err_ff == ERR_OK)) ? top_ff : '0;
         rsp_total_ff  <= (credit_ff && (err_ff == ERR_OK)) ? new_total : '0;
         rsp_depth_ff  <= sp_in;
         rsp_err_ff    <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_depth_ff, rsp_total_ff, rsp_id_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_credit_ff};

endmodule

// File: hdl/cset_checker.sv
// ----------------------------------------------------------------------------
// cset_checker
// port level checks of the exclusive time profiler, bound to the top level
// ----------------------------------------------------------------------------
module cset_checker import cset_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // an error never credits
   a_err_no_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:1] != ERR_OK) |-> !rsp_tuser[0])
      else $error("credit with error");

   // id and total are zero without credit
   a_no_credit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[39:0] == 40'd0))
      else $error("payload without credit");

   // depth within the stack
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[46:40] <= 7'(STACK_DEPTH)))
      else $error("depth out of range");

endmodule

bind call_stack_exclusive_time cset_checker u_cset_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
